>>> hw/rtl/parallel_strobe_block_transfer_assert.svh
// assertion macros for the parallel strobe block transfer checks
`ifndef PARALLEL_STROBE_BLOCK_TRANSFER_ASSERT_SVH
`define PARALLEL_STROBE_BLOCK_TRANSFER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PSBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/psbt_pkg.sv
package psbt_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_DONE     = 4'd1,
    PH_FAIL     = 4'd2,
    PH_CR_LO    = 4'd3,
    PH_CR_HI    = 4'd4,
    PH_SR_LO    = 4'd5,
    PH_SR_HI    = 4'd6,
    PH_CW_LO    = 4'd7,
    PH_CW_HI    = 4'd8,
    PH_CW_END   = 4'd9,
    PH_SW_FIRST = 4'd10,
    PH_SW_HI    = 4'd11,
    PH_SW_LO    = 4'd12
  } phase_t;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic ROLE_CLIENT = 1'b0;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] length;
    logic        ready_level;
    logic [7:0]  bus_in;
    logic        tick;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic        strobe_level;
    logic        drive_bus;
    logic [7:0]  bus_out;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        want_byte;
    logic [1:0]  status;
    logic [16:0] bytes_done;
  } out_item_t;

endpackage

>>> hw/rtl/parallel_strobe_block_transfer.sv
// an accepted item passes the input register, then the result register; one item per cycle
// while out_stall is low; the handshake step is one pass of logic on the held state
// in_stall rises only while the result register holds an item that out_stall keeps
// reset (rst, synchronous, active high): phase idle, strobe high, bus released, counters zero,
// role client, timeout 1000 ticks; both pipeline registers empty
module parallel_strobe_block_transfer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [psbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psbt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic [15:0]                        length,
  input  logic                               ready_level,
  input  logic [7:0]                         bus_in,
  input  logic                               tick,
  input  logic [7:0]                         write_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               strobe_level,
  output logic                               drive_bus,
  output logic [7:0]                         bus_out,
  output logic                               rx_valid,
  output logic [7:0]                         rx_byte,
  output logic                               want_byte,
  output logic [1:0]                         status,
  output logic [16:0]                        bytes_done
);

  psbt_pkg::in_item_t  in_item, s1_item;
  psbt_pkg::out_item_t res, out_item;
  logic                s1_valid, advance, fire;

  always_comb begin
    in_item.req_type    = req_type;
    in_item.length      = length;
    in_item.ready_level = ready_level;
    in_item.bus_in      = bus_in;
    in_item.tick        = tick;
    in_item.write_byte  = write_byte;
  end

  psbt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  assign fire = s1_valid && advance;

  psbt_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (s1_item),
    .res       (res)
  );

  psbt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign strobe_level = out_item.strobe_level;
  assign drive_bus    = out_item.drive_bus;
  assign bus_out      = out_item.bus_out;
  assign rx_valid     = out_item.rx_valid;
  assign rx_byte      = out_item.rx_byte;
  assign want_byte    = out_item.want_byte;
  assign status       = out_item.status;
  assign bytes_done   = out_item.bytes_done;

endmodule

>>> hw/rtl/psbt_in_stage.sv
module psbt_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  psbt_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               s1_valid,
  output psbt_pkg::in_item_t s1_item
);

  logic take;

  // the held item leaves when the result side has room
  assign take     = !s1_valid || advance;
  assign in_stall = !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      s1_item <= in_item;
    end
  end

endmodule

>>> hw/rtl/psbt_step.sv
module psbt_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [psbt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psbt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                fire,
  input  psbt_pkg::in_item_t                  item,
  output psbt_pkg::out_item_t                 res
);

  logic             role;
  logic [15:0]      timeout_ticks;

  psbt_pkg::phase_t phase, phase_next;
  logic             strobe_reg, strobe_reg_next;
  logic             drive_reg, drive_reg_next;
  logic [7:0]       out_byte, out_byte_next;
  logic [16:0]      byte_counter, byte_counter_next;
  logic [15:0]      block_length, block_length_next;
  logic [15:0]      wait_ticks, wait_ticks_next;
  logic [7:0]       next_byte, next_byte_next;
  logic             fetch_pending;

  logic             busy, want_high, met, ended, more_after_put;
  logic             want;
  logic             rx_v;
  logic [7:0]       rx_b;
  logic [16:0]      cnt_inc;
  logic [7:0]       nb;
  logic [1:0]       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      role          <= psbt_pkg::ROLE_CLIENT;
      timeout_ticks <= psbt_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psbt_pkg::CFG_ROLE:    role          <= cfg_data[0];
        psbt_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy    = (phase >= psbt_pkg::PH_CR_LO) && (phase <= psbt_pkg::PH_SW_LO);
  assign cnt_inc = byte_counter + 17'd1;
  assign ended   = byte_counter >= {1'b0, block_length};
  // want flag after a byte is put out: the new count still below the length
  assign more_after_put = cnt_inc < {1'b0, block_length};
  assign nb      = fetch_pending ? item.write_byte : next_byte;

  assign want_high = (phase == psbt_pkg::PH_CR_HI) || (phase == psbt_pkg::PH_SR_HI) ||
                     (phase == psbt_pkg::PH_CW_HI) || (phase == psbt_pkg::PH_CW_END) ||
                     (phase == psbt_pkg::PH_SW_HI);
  assign met = want_high ? item.ready_level : !item.ready_level;

  always_comb begin
    phase_next        = phase;
    strobe_reg_next   = strobe_reg;
    drive_reg_next    = drive_reg;
    out_byte_next     = out_byte;
    byte_counter_next = byte_counter;
    block_length_next = block_length;
    wait_ticks_next   = wait_ticks;
    next_byte_next    = next_byte;
    want              = 1'b0;
    rx_v              = 1'b0;
    rx_b              = 8'd0;

    if (!busy) begin
      if (item.req_type == psbt_pkg::REQ_READ || item.req_type == psbt_pkg::REQ_WRITE) begin
        block_length_next = item.length;
        byte_counter_next = 17'd0;
        wait_ticks_next   = 16'd0;
        if (item.req_type == psbt_pkg::REQ_READ) begin
          drive_reg_next = 1'b0;
          if (role == psbt_pkg::ROLE_CLIENT) begin
            strobe_reg_next = 1'b0;
            phase_next      = psbt_pkg::PH_CR_LO;
          end else begin
            phase_next = psbt_pkg::PH_SR_LO;
          end
        end else begin
          next_byte_next = item.write_byte;
          if (role == psbt_pkg::ROLE_CLIENT) begin
            drive_reg_next    = 1'b1;
            out_byte_next     = item.write_byte;
            byte_counter_next = 17'd1;
            strobe_reg_next   = 1'b0;
            phase_next        = psbt_pkg::PH_CW_LO;
            want              = 17'd1 < {1'b0, item.length};
          end else begin
            phase_next = psbt_pkg::PH_SW_FIRST;
          end
        end
      end
    end else begin
      next_byte_next = nb;
      if (met) begin
        wait_ticks_next = 16'd0;
        unique case (phase)
          psbt_pkg::PH_CR_LO: begin
            rx_v = 1'b1; rx_b = item.bus_in; byte_counter_next = cnt_inc;
            strobe_reg_next = 1'b1; phase_next = psbt_pkg::PH_CR_HI;
          end
          psbt_pkg::PH_CR_HI: begin
            if (ended) begin
              phase_next = psbt_pkg::PH_DONE;
            end else begin
              rx_v = 1'b1; rx_b = item.bus_in; byte_counter_next = cnt_inc;
              strobe_reg_next = 1'b0; phase_next = psbt_pkg::PH_CR_LO;
            end
          end
          psbt_pkg::PH_SR_LO: begin
            rx_v = 1'b1; rx_b = item.bus_in; byte_counter_next = cnt_inc;
            strobe_reg_next = 1'b0; phase_next = psbt_pkg::PH_SR_HI;
          end
          psbt_pkg::PH_SR_HI: begin
            strobe_reg_next = 1'b1;
            if (ended) begin
              phase_next = psbt_pkg::PH_DONE;
            end else begin
              rx_v = 1'b1; rx_b = item.bus_in; byte_counter_next = cnt_inc;
              phase_next = psbt_pkg::PH_SR_LO;
            end
          end
          psbt_pkg::PH_CW_LO: begin
            strobe_reg_next = 1'b1;
            if (ended) begin
              phase_next = psbt_pkg::PH_CW_END;
            end else begin
              out_byte_next = nb; byte_counter_next = cnt_inc;
              phase_next = psbt_pkg::PH_CW_HI; want = 1'b1;
            end
          end
          psbt_pkg::PH_CW_HI: begin
            out_byte_next = nb; byte_counter_next = cnt_inc;
            strobe_reg_next = 1'b0; phase_next = psbt_pkg::PH_CW_LO;
            want = more_after_put;
          end
          psbt_pkg::PH_CW_END: begin
            drive_reg_next = 1'b0; phase_next = psbt_pkg::PH_DONE;
          end
          psbt_pkg::PH_SW_FIRST: begin
            drive_reg_next = 1'b1; out_byte_next = nb; byte_counter_next = cnt_inc;
            strobe_reg_next = 1'b0; phase_next = psbt_pkg::PH_SW_HI;
            want = more_after_put;
          end
          psbt_pkg::PH_SW_HI: begin
            strobe_reg_next = 1'b1;
            if (ended) begin
              drive_reg_next = 1'b0; phase_next = psbt_pkg::PH_DONE;
            end else begin
              out_byte_next = nb; byte_counter_next = cnt_inc;
              phase_next = psbt_pkg::PH_SW_LO; want = 1'b1;
            end
          end
          default: begin
            // server write, waiting for ready low
            out_byte_next = nb; byte_counter_next = cnt_inc;
            strobe_reg_next = 1'b0; phase_next = psbt_pkg::PH_SW_HI;
            want = more_after_put;
          end
        endcase
      end else if (item.tick) begin
        if (wait_ticks >= timeout_ticks) begin
          wait_ticks_next = 16'd0;
          drive_reg_next  = 1'b0;
          strobe_reg_next = 1'b1;
          phase_next      = psbt_pkg::PH_FAIL;
        end else begin
          wait_ticks_next = wait_ticks + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= psbt_pkg::PH_IDLE;
      strobe_reg    <= 1'b1;
      drive_reg     <= 1'b0;
      out_byte      <= 8'd0;
      byte_counter  <= 17'd0;
      block_length  <= 16'd0;
      wait_ticks    <= 16'd0;
      next_byte     <= 8'd0;
      fetch_pending <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      strobe_reg    <= strobe_reg_next;
      drive_reg     <= drive_reg_next;
      out_byte      <= out_byte_next;
      byte_counter  <= byte_counter_next;
      block_length  <= block_length_next;
      wait_ticks    <= wait_ticks_next;
      next_byte     <= next_byte_next;
      fetch_pending <= want;
    end
  end

  always_comb begin
    priority if (phase_next == psbt_pkg::PH_DONE) begin
      status = psbt_pkg::ST_OK;
    end else if (phase_next == psbt_pkg::PH_FAIL) begin
      status = psbt_pkg::ST_FAIL;
    end else if (phase_next >= psbt_pkg::PH_CR_LO && phase_next <= psbt_pkg::PH_SW_LO) begin
      status = psbt_pkg::ST_BUSY;
    end else begin
      status = psbt_pkg::ST_IDLE;
    end
  end

  always_comb begin
    res.strobe_level = strobe_reg_next;
    res.drive_bus    = drive_reg_next;
    res.bus_out      = drive_reg_next ? out_byte_next : 8'd0;
    res.rx_valid     = rx_v;
    res.rx_byte      = rx_b;
    res.want_byte    = want;
    res.status       = status;
    res.bytes_done   = byte_counter_next;
  end

endmodule

>>> hw/rtl/psbt_out_stage.sv
module psbt_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  psbt_pkg::out_item_t res,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output psbt_pkg::out_item_t out_item
);

  // room when empty or when the held result is taken this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_item <= res;
    end
  end

endmodule

>>> hw/rtl/psbt_checker.sv
`include "parallel_strobe_block_transfer_assert.svh"

module psbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        drive_bus,
  input logic [7:0]  bus_out,
  input logic        rx_valid,
  input logic        want_byte,
  input logic [1:0]  status,
  input logic [16:0] bytes_done
);

  // a held result stays offered
  `PSBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // received bytes only arrive while the bus is released
  `PSBT_ASSERT_NOW(a_rx_no_drive, out_valid && rx_valid, !drive_bus, "byte received while driving")

  // released bus shows zero
  `PSBT_ASSERT_NOW(a_bus_zero, out_valid && !drive_bus, bus_out == 8'd0, "bus_out set while released")

  // outside a transfer no byte moves and nothing is requested
  `PSBT_ASSERT_NOW(a_quiet, out_valid && status != psbt_pkg::ST_BUSY,
                   !rx_valid && !want_byte, "activity outside a transfer")

  // idle is only seen before the first transfer
  `PSBT_ASSERT_NOW(a_idle_zero, out_valid && status == psbt_pkg::ST_IDLE,
                   bytes_done == 17'd0, "byte count set while idle")

endmodule

bind parallel_strobe_block_transfer psbt_checker u_psbt_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic       ROLE_SERVER = 1'b1;
  localparam int         PHASE_ITEMS = 200;
  localparam int         CYCLE_LIMIT = 400000;

  // tracks the link state and holds the pin results still owed by the block
  class strobe_link_scoreboard;
    logic                role_q;
    logic [15:0]         timeout_q;
    psbt_pkg::phase_t    ph;
    logic                strobe_q;
    logic                drive_q;
    logic [7:0]          out_byte_q;
    logic [7:0]          next_byte_q;
    logic                fetch_due;
    logic [16:0]         moved;
    logic [15:0]         block_len;
    logic [15:0]         waited;
    psbt_pkg::out_item_t cur;
    psbt_pkg::out_item_t pins_due[$];
    int                  mismatches;
    int                  results_seen;
    int                  starts;
    int                  finished;
    int                  timeouts;

    function new();
      role_q = psbt_pkg::ROLE_CLIENT;
      timeout_q = psbt_pkg::TIMEOUT_RESET;
      ph = psbt_pkg::PH_IDLE;
      strobe_q = 1'b1;
      drive_q = 1'b0;
      out_byte_q = '0;
      next_byte_q = '0;
      fetch_due = 1'b0;
      moved = '0;
      block_len = '0;
      waited = '0;
      mismatches = 0;
      results_seen = 0;
      starts = 0;
      finished = 0;
      timeouts = 0;
    endfunction

    function bit busy();
      return ph >= psbt_pkg::PH_CR_LO && ph <= psbt_pkg::PH_SW_LO;
    endfunction

    // level of the partner's ready line that the current wait looks for
    function logic awaited_level();
      return ph == psbt_pkg::PH_CR_HI || ph == psbt_pkg::PH_SR_HI ||
             ph == psbt_pkg::PH_CW_HI || ph == psbt_pkg::PH_CW_END ||
             ph == psbt_pkg::PH_SW_HI;
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    function void take_byte(logic [7:0] b);
      cur.rx_valid = 1'b1;
      cur.rx_byte = b;
      moved = moved + 17'd1;
    endfunction

    function void send_byte(logic [7:0] b);
      out_byte_q = b;
      moved = moved + 17'd1;
    endfunction

    function void note_item(psbt_pkg::in_item_t it);
      logic             want;
      logic             met;
      logic             ended;
      psbt_pkg::phase_t prev;
      cur = '0;
      want = 1'b0;
      prev = ph;
      if (!busy()) begin
        if (it.req_type == psbt_pkg::REQ_READ || it.req_type == psbt_pkg::REQ_WRITE) begin
          starts++;
          block_len = it.length;
          moved = '0;
          waited = '0;
          fetch_due = 1'b0;
          if (it.req_type == psbt_pkg::REQ_READ) begin
            drive_q = 1'b0;
            if (role_q == psbt_pkg::ROLE_CLIENT) begin
              strobe_q = 1'b0;
              ph = psbt_pkg::PH_CR_LO;
            end else begin
              ph = psbt_pkg::PH_SR_LO;
            end
          end else begin
            next_byte_q = it.write_byte;
            if (role_q == psbt_pkg::ROLE_CLIENT) begin
              drive_q = 1'b1;
              send_byte(next_byte_q);
              strobe_q = 1'b0;
              ph = psbt_pkg::PH_CW_LO;
              want = moved < {1'b0, block_len};
            end else begin
              ph = psbt_pkg::PH_SW_FIRST;
            end
          end
        end
      end else begin
        // byte asked for by the previous item arrives now
        if (fetch_due) begin
          next_byte_q = it.write_byte;
          fetch_due = 1'b0;
        end
        met = awaited_level() ? it.ready_level : !it.ready_level;
        if (met) begin
          ended = moved >= {1'b0, block_len};
          waited = '0;
          case (ph)
            psbt_pkg::PH_CR_LO: begin
              take_byte(it.bus_in);
              strobe_q = 1'b1;
              ph = psbt_pkg::PH_CR_HI;
            end
            psbt_pkg::PH_CR_HI: begin
              if (ended) begin
                ph = psbt_pkg::PH_DONE;
              end else begin
                take_byte(it.bus_in);
                strobe_q = 1'b0;
                ph = psbt_pkg::PH_CR_LO;
              end
            end
            psbt_pkg::PH_SR_LO: begin
              take_byte(it.bus_in);
              strobe_q = 1'b0;
              ph = psbt_pkg::PH_SR_HI;
            end
            psbt_pkg::PH_SR_HI: begin
              strobe_q = 1'b1;
              if (ended) begin
                ph = psbt_pkg::PH_DONE;
              end else begin
                take_byte(it.bus_in);
                ph = psbt_pkg::PH_SR_LO;
              end
            end
            psbt_pkg::PH_CW_LO: begin
              strobe_q = 1'b1;
              if (ended) begin
                ph = psbt_pkg::PH_CW_END;
              end else begin
                send_byte(next_byte_q);
                ph = psbt_pkg::PH_CW_HI;
                want = 1'b1;
              end
            end
            psbt_pkg::PH_CW_HI: begin
              send_byte(next_byte_q);
              strobe_q = 1'b0;
              ph = psbt_pkg::PH_CW_LO;
              want = moved < {1'b0, block_len};
            end
            psbt_pkg::PH_CW_END: begin
              drive_q = 1'b0;
              ph = psbt_pkg::PH_DONE;
            end
            psbt_pkg::PH_SW_FIRST: begin
              drive_q = 1'b1;
              send_byte(next_byte_q);
              strobe_q = 1'b0;
              ph = psbt_pkg::PH_SW_HI;
              want = moved < {1'b0, block_len};
            end
            psbt_pkg::PH_SW_HI: begin
              strobe_q = 1'b1;
              if (ended) begin
                drive_q = 1'b0;
                ph = psbt_pkg::PH_DONE;
              end else begin
                send_byte(next_byte_q);
                ph = psbt_pkg::PH_SW_LO;
                want = 1'b1;
              end
            end
            default: begin
              send_byte(next_byte_q);
              strobe_q = 1'b0;
              ph = psbt_pkg::PH_SW_HI;
              want = moved < {1'b0, block_len};
            end
          endcase
        end else if (it.tick) begin
          if (waited >= timeout_q) begin
            waited = '0;
            drive_q = 1'b0;
            strobe_q = 1'b1;
            ph = psbt_pkg::PH_FAIL;
            timeouts++;
          end else begin
            waited = waited + 16'd1;
          end
        end
      end
      fetch_due = want;
      if (ph == psbt_pkg::PH_DONE && prev != psbt_pkg::PH_DONE) finished++;

      cur.strobe_level = strobe_q;
      cur.drive_bus = drive_q;
      cur.bus_out = drive_q ? out_byte_q : 8'd0;
      cur.want_byte = want;
      cur.bytes_done = moved;
      if (ph == psbt_pkg::PH_DONE) cur.status = psbt_pkg::ST_OK;
      else if (ph == psbt_pkg::PH_FAIL) cur.status = psbt_pkg::ST_FAIL;
      else if (busy()) cur.status = psbt_pkg::ST_BUSY;
      else cur.status = psbt_pkg::ST_IDLE;
      pins_due.push_back(cur);
    endfunction

    function string pins_str(psbt_pkg::out_item_t p);
      return $sformatf("strobe=%b drive=%b bus=%h rxv=%b rx=%h want=%b status=%0d done=%0d",
                       p.strobe_level, p.drive_bus, p.bus_out, p.rx_valid, p.rx_byte,
                       p.want_byte, p.status, p.bytes_done);
    endfunction

    function void check_result(psbt_pkg::out_item_t got);
      psbt_pkg::out_item_t exp_pins;
      results_seen++;
      if (pins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", pins_str(got));
        return;
      end
      exp_pins = pins_due.pop_front();
      if (got !== exp_pins) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch\n  expected %s\n  actual   %s",
                   results_seen, pins_str(exp_pins), pins_str(got));
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [psbt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [psbt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      req_type = '0;
  logic [15:0]                     length = '0;
  logic                            ready_level = 1'b0;
  logic [7:0]                      bus_in = '0;
  logic                            tick = 1'b0;
  logic [7:0]                      write_byte = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            strobe_level;
  logic                            drive_bus;
  logic [7:0]                      bus_out;
  logic                            rx_valid;
  logic [7:0]                      rx_byte;
  logic                            want_byte;
  logic [1:0]                      status;
  logic [16:0]                     bytes_done;

  strobe_link_scoreboard sb = new();
  bit no_gaps = 1'b0;
  bit partner_silent = 1'b0;
  int stall_left = 0;
  int cycles = 0;

  parallel_strobe_block_transfer DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .length(length), .ready_level(ready_level),
    .bus_in(bus_in), .tick(tick), .write_byte(write_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .strobe_level(strobe_level), .drive_bus(drive_bus), .bus_out(bus_out),
    .rx_valid(rx_valid), .rx_byte(rx_byte), .want_byte(want_byte),
    .status(status), .bytes_done(bytes_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("parallel_strobe_block_transfer test failed");
      $finish;
    end
  end

  // result side: check each accepted result, then hold stall at random, never while no_gaps is set
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      sb.check_result({strobe_level, drive_bus, bus_out, rx_valid, rx_byte,
                       want_byte, status, bytes_done});
      n = no_gaps ? 0 : $urandom_range(0, 9);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  function automatic psbt_pkg::in_item_t mk(logic [1:0] r, logic [15:0] len, logic rdy,
                                            logic [7:0] b, logic t, logic [7:0] wb);
    return '{r, len, rdy, b, t, wb};
  endfunction

  // partner model: answers the awaited ready level most of the time, or goes silent
  function automatic psbt_pkg::in_item_t pick_item(input bit quiet_ok);
    psbt_pkg::in_item_t it;
    it.req_type = psbt_pkg::REQ_SAMPLE;
    it.length = 16'($urandom);
    it.bus_in = 8'($urandom);
    it.write_byte = 8'($urandom);
    it.ready_level = 1'($urandom);
    if (!sb.busy()) begin
      case ($urandom_range(0, 9))
        0: it.req_type = psbt_pkg::REQ_SAMPLE;
        1: it.req_type = REQ_UNUSED;
        2, 3, 4, 5: it.req_type = psbt_pkg::REQ_READ;
        default: it.req_type = psbt_pkg::REQ_WRITE;
      endcase
      if (it.req_type == psbt_pkg::REQ_READ || it.req_type == psbt_pkg::REQ_WRITE) begin
        partner_silent = quiet_ok && ($urandom_range(0, 4) == 0);
        // long blocks only when the partner drops out and the wait times out
        if (!(partner_silent && $urandom_range(0, 1) == 1))
          it.length = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      end
    end else begin
      case ($urandom_range(0, 15))
        0: it.req_type = psbt_pkg::REQ_READ;
        1: it.req_type = psbt_pkg::REQ_WRITE;
        2: it.req_type = REQ_UNUSED;
        default: it.req_type = psbt_pkg::REQ_SAMPLE;
      endcase
      if (partner_silent) it.ready_level = !sb.awaited_level();
      else if ($urandom_range(0, 2) != 0) it.ready_level = sb.awaited_level();
      else it.ready_level = !sb.awaited_level();
    end
    it.tick = partner_silent ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic send_item(input psbt_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req_type;
    length <= it.length;
    ready_level <= it.ready_level;
    bus_in <= it.bus_in;
    tick <= it.tick;
    write_byte <= it.write_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic run_random(input int target, input bit quiet_ok);
    int                 counted;
    bit                 counts;
    psbt_pkg::in_item_t it;
    counted = 0;
    partner_silent = 1'b0;
    while (counted < target) begin
      if (counted % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      it = pick_item(quiet_ok);
      counts = sb.busy() || it.req_type == psbt_pkg::REQ_READ ||
               it.req_type == psbt_pkg::REQ_WRITE;
      send_item(it);
      if (counts) counted++;
    end
    // let any open transfer end before the settings change
    while (sb.busy()) send_item(pick_item(quiet_ok));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_setting(input logic role_v, input logic [15:0] timeout_v,
                             input bit quiet_ok);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= psbt_pkg::CFG_ROLE;
    cfg_data <= {{(psbt_pkg::CFG_DATA_W-1){1'b0}}, role_v};
    @(posedge clk);
    cfg_index <= psbt_pkg::CFG_TIMEOUT;
    cfg_data <= timeout_v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.role_q = role_v;
    sb.timeout_q = timeout_v;
    run_random(PHASE_ITEMS, quiet_ok);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // client side at reset settings: idle noise, odd code, short read and write blocks
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 8'hFF));
    send_item(mk(REQ_UNUSED,           16'h0000, 1'b0, 8'h00, 1'b0, 8'h00));
    send_item(mk(psbt_pkg::REQ_READ,   16'd0,    1'b1, 8'h00, 1'b0, 8'h00));
    send_item(mk(psbt_pkg::REQ_WRITE,  16'd5,    1'b1, 8'h3C, 1'b1, 8'h77)); // start while busy
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'd0,    1'b0, 8'hA5, 1'b1, 8'h00)); // level met with tick
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'd0,    1'b1, 8'h5A, 1'b0, 8'h00));
    send_item(mk(psbt_pkg::REQ_WRITE,  16'd2,    1'b0, 8'h00, 1'b0, 8'h00));
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'd0,    1'b0, 8'h00, 1'b0, 8'hFF));
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'd0,    1'b1, 8'h00, 1'b0, 8'h81)); // even length
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'd0,    1'b0, 8'h00, 1'b0, 8'h00));
    send_item(mk(psbt_pkg::REQ_SAMPLE, 16'd0,    1'b1, 8'h00, 1'b0, 8'h00));

    run_random(PHASE_ITEMS, 1'b0);
    run_setting(ROLE_SERVER, 16'd3, 1'b1);
    run_setting(psbt_pkg::ROLE_CLIENT, 16'd0, 1'b1);
    run_setting(ROLE_SERVER, 16'hFFFF, 1'b0);
    run_setting(psbt_pkg::ROLE_CLIENT, 16'd10, 1'b1);
    run_setting(ROLE_SERVER, 16'd0, 1'b1);
    run_setting(psbt_pkg::ROLE_CLIENT, 16'hFFFF, 1'b0);
    drain();

    $display("checked %0d results over seven settings of role and timeout (0 to 65535)",
             sb.results_seen);
    $display("transfers started %0d, finished %0d, timed out %0d; mismatches %0d",
             sb.starts, sb.finished, sb.timeouts, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("parallel_strobe_block_transfer test passed");
    end else begin
      $display("parallel_strobe_block_transfer test failed");
    end
    $finish;
  end

endmodule
